// ===== rtl/silm_pkg.sv =====
// Shared types and constants of the shared interrupt line manager.
package silm_pkg;

    localparam int LINES_DEF = 16;
    localparam int SLOTS_DEF = 32;

    localparam int CNT_W  = 32;
    localparam int INTV_W = 31;

    localparam logic [INTV_W-1:0] INTERVAL_START = 31'd100;
    localparam logic [INTV_W-1:0] INTERVAL_LIMIT = 31'd1073741823;

    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_IRQ      = 3'd2;
    localparam logic [2:0] REQ_ENABLE   = 3'd3;
    localparam logic [2:0] REQ_DISABLE  = 3'd4;

    localparam logic [1:0] USE_NONE = 2'd0;
    localparam logic [1:0] USE_ADD  = 2'd1;
    localparam logic [1:0] USE_DROP = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_MOD,
        S_DONE
    } t_state;

endpackage

// ===== rtl/shared_irq_line_manager_unit.sv =====
// Top level of the shared interrupt line manager.
//
// Input channel: one request word (req_type, line, slot, done_mask) is taken
// when i_in_valid is high and o_in_stall is low. Output channel: one result
// word per request, held in an output register while i_out_stall is high.
// Per-line state (registered mask, active mask, mask flag, spurious count)
// sits in one synchronous memory; each request is a read, a compute cycle
// and a write-back, in which the result word is loaded into the output
// register. A spurious interrupt whose count is past one and with a
// nonzero interval also runs the bit-serial remainder unit between the
// compute and write-back steps.
// One request is in work at a time; the next is taken as soon as the
// result is loaded into the output register, even if that word still waits.
// A stalled receiver holds the result and, once the next request is computed,
// holds that request in its write-back step until the register frees.
// Reset (synchronous, active low) clears the per-line valid bits so every
// line reads as unused and masked with a zero count, and sets the report
// interval to 100. No clearing pass is needed.
module shared_irq_line_manager_unit #(
    parameter int LINES = silm_pkg::LINES_DEF,
    parameter int SLOTS = silm_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_req_type,
    input  logic [3:0]                  i_line,
    input  logic [4:0]                  i_slot,
    input  logic [31:0]                 i_done_mask,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [4:0]                  o_slot_given,
    output logic                        o_status,
    output logic                        o_line_masked,
    output logic [1:0]                  o_use_event,
    output logic                        o_ack,
    output logic                        o_spurious,
    output logic                        o_spurious_report,
    output logic [silm_pkg::CNT_W-1:0]  o_spurious_total,
    output logic                        o_was_enabled
);
    import silm_pkg::*;

    localparam int LW  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LXW = (LW > 4) ? LW : 4;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GW  = (SW > 5) ? SW : 5;
    localparam int EW  = 2 * SLOTS + 1 + CNT_W;
    localparam int MSK_B = CNT_W;
    localparam int ACT_B = CNT_W + 1;
    localparam int REG_B = CNT_W + 1 + SLOTS;

    t_state r_state, n_state;

    logic [EW-1:0]      mem [LINES];
    logic [LINES-1:0]   r_vld;
    logic [EW-1:0]      r_rd_data;
    logic               r_rd_vld;

    logic [2:0]         r_req;
    logic [4:0]         r_slot;
    logic [31:0]        r_done;
    logic [LW-1:0]      r_idx;
    logic               r_line_ok;
    logic               r_slot_ok;

    logic [SLOTS-1:0]   r_reg_m, r_act_m;
    logic               r_msk;
    logic [CNT_W-1:0]   r_cnt;
    logic [4:0]         r_given;
    logic               r_status, r_ack, r_spur, r_was, r_need_mod, r_c_one;
    logic [1:0]         r_use;
    logic [INTV_W-1:0]  r_intv;

    logic               r_out_valid;
    logic [4:0]         r_o_given;
    logic               r_o_status, r_o_masked, r_o_ack, r_o_spur, r_o_rep, r_o_was;
    logic [1:0]         r_o_use;
    logic [CNT_W-1:0]   r_o_total;

    logic               in_acc, out_free, load, mem_we, mod_start, mod_done, rep;
    logic [LXW-1:0]     line_x;
    logic [LW-1:0]      in_idx;
    logic [INTV_W-1:0]  mod_rem;

    logic [SLOTS-1:0]   e_reg, e_act, bit_m, free_m, low_m, done_m;
    logic               e_msk;
    logic [CNT_W-1:0]   e_cnt;
    logic [SW-1:0]      low_idx;
    logic [GW-1:0]      given_x;

    logic [SLOTS-1:0]   n_reg_m, n_act_m;
    logic               n_msk;
    logic [CNT_W-1:0]   n_cnt;
    logic [4:0]         n_given;
    logic               n_status, n_ack, n_spur, n_was, n_need_mod, n_c_one;
    logic [1:0]         n_use;

    assign line_x   = LXW'(i_line);
    assign in_idx   = line_x[LW-1:0];
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_CALC;
            S_CALC:  n_state = n_need_mod ? S_MOD : S_DONE;
            S_MOD:   if (mod_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        mod_start  = 1'b0;
        load       = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_CALC:  mod_start = n_need_mod;
            S_MOD:   ;
            S_DONE:  load = out_free;
            default: ;
        endcase
    end

    assign mem_we = load && r_line_ok;

    // per-line update
    always_comb begin
        e_reg = r_rd_vld ? r_rd_data[REG_B +: SLOTS] : '0;
        e_act = r_rd_vld ? r_rd_data[ACT_B +: SLOTS] : '0;
        e_msk = r_rd_vld ? r_rd_data[MSK_B] : 1'b1;
        e_cnt = r_rd_vld ? r_rd_data[CNT_W-1:0] : '0;

        bit_m  = r_slot_ok ? (SLOTS'(1) << r_slot) : '0;
        done_m = SLOTS'(r_done);
        free_m = ~e_reg;
        low_m  = free_m & (~free_m + SLOTS'(1));
        low_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (low_m[i]) low_idx = low_idx | SW'(i);
        end
        given_x = GW'(low_idx);

        n_reg_m    = e_reg;
        n_act_m    = e_act;
        n_msk      = e_msk;
        n_cnt      = e_cnt;
        n_given    = '0;
        n_status   = 1'b0;
        n_use      = USE_NONE;
        n_ack      = 1'b0;
        n_spur     = 1'b0;
        n_was      = 1'b0;
        n_need_mod = 1'b0;
        n_c_one    = 1'b0;

        case (r_req)
            REQ_REGISTER: begin
                if (free_m == '0) begin
                    n_status = 1'b1;
                end else begin
                    n_reg_m = e_reg | low_m;
                    n_given = given_x[4:0];
                    n_act_m = e_act & ~low_m;
                    if (n_act_m == '0) begin
                        n_use = USE_ADD;
                        n_msk = 1'b0;
                    end
                end
            end
            REQ_REMOVE: begin
                if (r_slot_ok) begin
                    n_reg_m = e_reg & ~bit_m;
                    n_act_m = e_act & ~bit_m;
                    if (n_reg_m == '0) begin
                        n_msk = 1'b1;
                        n_use = USE_DROP;
                    end else if (n_act_m == '0) begin
                        n_msk = 1'b0;
                    end
                end
            end
            REQ_IRQ: begin
                n_msk = 1'b1;
                if (e_reg == '0) begin
                    n_cnt      = (e_cnt == '1) ? e_cnt : e_cnt + CNT_W'(1);
                    n_spur     = 1'b1;
                    n_c_one    = (n_cnt == CNT_W'(1));
                    n_need_mod = !n_c_one && (r_intv != '0);
                end else begin
                    n_act_m = (e_act | e_reg) & ~(done_m & e_reg);
                    if (n_act_m == '0) n_msk = 1'b0;
                    n_ack = 1'b1;
                end
            end
            REQ_ENABLE: begin
                if (r_slot_ok) begin
                    n_act_m = e_act & ~bit_m;
                    if (n_act_m == '0) n_msk = 1'b0;
                end
            end
            REQ_DISABLE: begin
                if (r_slot_ok && (e_act & bit_m) == '0) begin
                    n_act_m = e_act | bit_m;
                    n_msk   = 1'b1;
                    n_was   = 1'b1;
                end
            end
            default: ;
        endcase

        if (!r_line_ok) begin
            n_msk      = 1'b1;
            n_cnt      = '0;
            n_given    = '0;
            n_status   = 1'b0;
            n_use      = USE_NONE;
            n_ack      = 1'b0;
            n_spur     = 1'b0;
            n_was      = 1'b0;
            n_need_mod = 1'b0;
            n_c_one    = 1'b0;
        end
    end

    assign rep = r_spur && (r_c_one || (r_need_mod && mod_rem == '0));

    silm_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (n_cnt),
        .i_divisor  (r_intv),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // line state memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= {r_reg_m, r_act_m, r_msk, r_cnt};
        end
        if (in_acc) begin
            r_rd_data <= mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_intv      <= INTERVAL_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) r_vld[r_idx] <= 1'b1;
            if (load && rep && r_intv < INTERVAL_LIMIT) begin
                r_intv <= {r_intv[INTV_W-2:0], 1'b0};
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req     <= i_req_type;
            r_slot    <= i_slot;
            r_done    <= i_done_mask;
            r_idx     <= in_idx;
            r_line_ok <= {28'd0, i_line} < 32'(LINES);
            r_slot_ok <= {27'd0, i_slot} < 32'(SLOTS);
            r_rd_vld  <= r_vld[in_idx];
        end
        if (r_state == S_CALC) begin
            r_reg_m    <= n_reg_m;
            r_act_m    <= n_act_m;
            r_msk      <= n_msk;
            r_cnt      <= n_cnt;
            r_given    <= n_given;
            r_status   <= n_status;
            r_use      <= n_use;
            r_ack      <= n_ack;
            r_spur     <= n_spur;
            r_was      <= n_was;
            r_need_mod <= n_need_mod;
            r_c_one    <= n_c_one;
        end
        if (load) begin
            r_o_given  <= r_given;
            r_o_status <= r_status;
            r_o_masked <= r_msk;
            r_o_use    <= r_use;
            r_o_ack    <= r_ack;
            r_o_spur   <= r_spur;
            r_o_rep    <= rep;
            r_o_total  <= r_cnt;
            r_o_was    <= r_was;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_slot_given      = r_o_given;
    assign o_status          = r_o_status;
    assign o_line_masked     = r_o_masked;
    assign o_use_event       = r_o_use;
    assign o_ack             = r_o_ack;
    assign o_spurious        = r_o_spur;
    assign o_spurious_report = r_o_rep;
    assign o_spurious_total  = r_o_total;
    assign o_was_enabled     = r_o_was;

    a_ack_not_spur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack |-> !o_spurious && !o_status)
        else $error("ack together with spurious or full");

    a_spur_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_spurious |-> o_line_masked)
        else $error("spurious interrupt left line unmasked");

    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_slot_given == 5'd0 && o_use_event == USE_NONE)
        else $error("full line reported a slot or use change");

    a_mod_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOD |-> r_need_mod && r_spur)
        else $error("remainder wait without spurious interrupt");

endmodule

// ===== rtl/silm_mod.sv =====
// Bit-serial remainder unit: one restoring step per cycle over the dividend bits.
module silm_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [silm_pkg::CNT_W-1:0]   i_dividend,
    input  logic [silm_pkg::INTV_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [silm_pkg::INTV_W-1:0]  o_rem
);
    import silm_pkg::*;

    localparam int CW = $clog2(CNT_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [CNT_W-1:0]  r_dvd;
    logic [INTV_W-1:0] r_dvs;
    logic [INTV_W-1:0] r_rem;

    logic [CNT_W-1:0]  rem_sh;
    logic [CNT_W:0]    diff;

    assign rem_sh = {r_rem, r_dvd[CNT_W-1]};
    assign diff   = {1'b0, rem_sh} - {{(CNT_W-INTV_W+1){1'b0}}, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(CNT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[CNT_W-2:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
            if (!diff[CNT_W]) begin
                r_rem <= diff[INTV_W-1:0];
            end else begin
                r_rem <= rem_sh[INTV_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("done without a running division");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_rem < r_dvs)
        else $error("remainder not below divisor");

endmodule
